// ===== hdl/lfu_pkg.sv =====
// Package for the LFU cache: sizes, entry layout, command and register codes.
// Used by the cache top level and its checker; no dependencies.
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int STAMP_BITS = 48;
  localparam int DATA_BITS  = 32;
  localparam int CAP_BITS   = 5;
  localparam int APB_BITS   = 32;
  localparam int ADDR_BITS  = 3;

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int CMP_BITS = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic [COUNT_BITS-1:0]       count_t;
  typedef logic [STAMP_BITS-1:0]       stamp_t;
  typedef logic [IDX_BITS-1:0]         idx_t;
  typedef logic [CAP_BITS-1:0]         cap_t;

  typedef struct packed {
    data_t  key;
    data_t  value;
    count_t count;
    stamp_t stamp;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam cap_t   CAP_RESET = CAP_BITS'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // register index field of paddr
  localparam logic [ADDR_BITS-3:0] REG_CAPACITY = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

// ===== hdl/lfu_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lfu_cache_with_lru_ties.sv =====
// LFU cache top level: APB register, entry scan and write-back sequencer.
// Depends on lfu_pkg and lfu_ram.
//
//   port group | direction | handshake             | beat contents
//   in_*       | sink      | in_valid / in_ready   | command, key, value
//   out_*      | source    | out_valid / out_ready | hit, read_value, evicted, evicted_key
//   apb        | sink      | psel/penable, pready  | capacity register
//
// A beat goes through accept, one read of the entry RAM per entry plus the RAM's
// registered read latency, and write-back.
// Reset is synchronous, active low; it clears valid marks at once, no sweep.
// A finished result waits in the output register; the next beat is accepted
// meanwhile and stalls only at its own write-back while that register is full.
module lfu_cache_with_lru_ties (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic signed [lfu_pkg::DATA_BITS-1:0]   in_key,
  input  logic signed [lfu_pkg::DATA_BITS-1:0]   in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_hit,
  output logic signed [lfu_pkg::DATA_BITS-1:0]   out_read_value,
  output logic                                   out_evicted,
  output logic signed [lfu_pkg::DATA_BITS-1:0]   out_evicted_key,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lfu_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [lfu_pkg::APB_BITS-1:0]           pwdata,
  output logic [lfu_pkg::APB_BITS-1:0]           prdata,
  output logic                                   pready
);

  lfu_pkg::state_t state_r, state_nxt;

  lfu_pkg::cap_t                      capacity_r;
  logic [lfu_pkg::ENTRIES-1:0]        valid_r;
  logic [lfu_pkg::CNT_BITS-1:0]       occ_r;
  lfu_pkg::stamp_t                    touch_r;
  logic [lfu_pkg::CNT_BITS-1:0]       cnt_r;

  logic                               cmd_r;
  lfu_pkg::data_t                     key_r, val_r;

  logic                               found_r, free_found_r, vic_found_r;
  lfu_pkg::idx_t                      hit_idx_r, free_idx_r, vic_idx_r;
  lfu_pkg::entry_t                    hit_ent_r, vic_ent_r;

  logic                               out_valid_r, out_hit_r, out_evicted_r;
  lfu_pkg::data_t                     out_read_value_r, out_evicted_key_r;

  logic                               accept, commit, cfg_wr;
  logic                               chk_en, chk_valid;
  lfu_pkg::idx_t                      chk_idx;
  logic [lfu_pkg::ENTRY_BITS-1:0]     rd_bits;
  lfu_pkg::entry_t                    rd_ent;

  logic [lfu_pkg::CMP_BITS-1:0]       cap_eff;
  logic                               wr_en, occ_inc;
  lfu_pkg::idx_t                      wr_idx;
  lfu_pkg::entry_t                    wr_ent;
  lfu_pkg::stamp_t                    stamp_nxt;
  logic                               res_hit, res_ev;
  lfu_pkg::data_t                     res_rd, res_evk;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[lfu_pkg::ADDR_BITS-1:2] == lfu_pkg::REG_CAPACITY);

  always_comb begin
    prdata = '0;
    if (paddr[lfu_pkg::ADDR_BITS-1:2] == lfu_pkg::REG_CAPACITY) begin
      prdata = lfu_pkg::APB_BITS'(capacity_r);
    end
  end

  // ---------------- entry memory ----------------
  lfu_ram #(
    .WIDTH (lfu_pkg::ENTRY_BITS),
    .DEPTH (lfu_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (commit && wr_en),
    .waddr (wr_idx),
    .wdata (wr_ent),
    .raddr (cnt_r[lfu_pkg::IDX_BITS-1:0]),
    .rdata (rd_bits)
  );

  assign rd_ent    = lfu_pkg::entry_t'(rd_bits);
  assign chk_idx   = lfu_pkg::IDX_BITS'(cnt_r - 1'b1);
  assign chk_en    = (state_r == lfu_pkg::ST_SCAN) && (cnt_r != '0);
  assign chk_valid = valid_r[chk_idx];

  // ---------------- FSM ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (cnt_r == lfu_pkg::CNT_BITS'(lfu_pkg::ENTRIES)) begin
          state_nxt = lfu_pkg::ST_WRITE;
        end
      end
      lfu_pkg::ST_WRITE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = lfu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == lfu_pkg::ST_IDLE);
    commit   = (state_r == lfu_pkg::ST_WRITE) && (!out_valid_r || out_ready);
  end

  assign accept = in_valid && in_ready;

  // ---------------- write-back decision ----------------
  always_comb begin
    if (lfu_pkg::CMP_BITS'(capacity_r) > lfu_pkg::CMP_BITS'(lfu_pkg::ENTRIES)) begin
      cap_eff = lfu_pkg::CMP_BITS'(lfu_pkg::ENTRIES);
    end else begin
      cap_eff = lfu_pkg::CMP_BITS'(capacity_r);
    end

    stamp_nxt = touch_r + 1'b1;
    wr_en     = 1'b0;
    occ_inc   = 1'b0;
    wr_idx    = hit_idx_r;
    wr_ent    = hit_ent_r;
    res_hit   = 1'b0;
    res_rd    = '1;
    res_ev    = 1'b0;
    res_evk   = '0;

    if (found_r) begin
      res_hit = 1'b1;
      wr_en   = 1'b1;
      if (cmd_r == lfu_pkg::CMD_GET) begin
        res_rd = hit_ent_r.value;
      end else begin
        wr_ent.value = val_r;
      end
      if (hit_ent_r.count != lfu_pkg::COUNT_MAX) begin
        wr_ent.count = hit_ent_r.count + 1'b1;
      end
      wr_ent.stamp = stamp_nxt;
    end else if (cmd_r == lfu_pkg::CMD_PUT && cap_eff != '0) begin
      wr_ent.key   = key_r;
      wr_ent.value = val_r;
      wr_ent.count = lfu_pkg::COUNT_BITS'(1);
      wr_ent.stamp = stamp_nxt;
      if (lfu_pkg::CMP_BITS'(occ_r) >= cap_eff) begin
        wr_idx  = vic_idx_r;
        wr_en   = vic_found_r;
        res_ev  = vic_found_r;
        res_evk = vic_found_r ? vic_ent_r.key : '0;
      end else begin
        wr_idx  = free_idx_r;
        wr_en   = free_found_r;
        occ_inc = free_found_r;
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lfu_pkg::ST_IDLE;
      capacity_r   <= lfu_pkg::CAP_RESET;
      valid_r      <= '0;
      occ_r        <= '0;
      touch_r      <= '0;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      vic_found_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        capacity_r <= pwdata[lfu_pkg::CAP_BITS-1:0];
      end
      if (accept) begin
        cnt_r        <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        vic_found_r  <= 1'b0;
      end else if (state_r == lfu_pkg::ST_SCAN) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (chk_en && chk_valid) begin
        if (rd_ent.key == key_r) begin
          found_r <= 1'b1;
        end
        if (!vic_found_r
            || rd_ent.count < vic_ent_r.count
            || (rd_ent.count == vic_ent_r.count && rd_ent.stamp < vic_ent_r.stamp)) begin
          vic_found_r <= 1'b1;
        end
      end
      if (chk_en && !chk_valid) begin
        free_found_r <= 1'b1;
      end
      if (commit && wr_en) begin
        valid_r[wr_idx] <= 1'b1;
        touch_r         <= stamp_nxt;
      end
      if (commit && occ_inc) begin
        occ_r <= occ_r + 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (chk_en && chk_valid) begin
      if (rd_ent.key == key_r) begin
        hit_idx_r <= chk_idx;
        hit_ent_r <= rd_ent;
      end
      if (!vic_found_r
          || rd_ent.count < vic_ent_r.count
          || (rd_ent.count == vic_ent_r.count && rd_ent.stamp < vic_ent_r.stamp)) begin
        vic_idx_r <= chk_idx;
        vic_ent_r <= rd_ent;
      end
    end
    if (chk_en && !chk_valid && !free_found_r) begin
      free_idx_r <= chk_idx;
    end
    if (commit) begin
      out_hit_r         <= res_hit;
      out_read_value_r  <= res_rd;
      out_evicted_r     <= res_ev;
      out_evicted_key_r <= res_evk;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

// ===== hdl/lfu_chk.sv =====
// Port-level checker for the LFU cache, bound to the top level.
// Depends on lfu_pkg.
module lfu_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_hit,
  input logic signed [lfu_pkg::DATA_BITS-1:0] out_read_value,
  input logic                                 out_evicted,
  input logic signed [lfu_pkg::DATA_BITS-1:0] out_evicted_key
);

  // one beat in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted beat");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_read_value == {lfu_pkg::DATA_BITS{1'b1}})
    else $error("read_value not all ones on a miss");

  a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted_key nonzero without eviction");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit)
    else $error("eviction reported on a hit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
                                && $stable(out_evicted_key))
    else $error("result changed while stalled");

endmodule

bind lfu_cache_with_lru_ties lfu_chk u_lfu_chk (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for lfu_cache_with_lru_ties: a directed table, then random get/put traffic over
// several capacities and stall mixes; results checked against typed rows or cache model.
// Depends on lfu_pkg and the cache RTL.
module tb_top;

  typedef struct packed {
    logic           hit;
    lfu_pkg::data_t read_value;
    logic           evicted;
    lfu_pkg::data_t evicted_key;
  } lookup_t;

  typedef enum logic {ROW_BEAT, ROW_CAPACITY} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic           command;
    lfu_pkg::data_t key;
    lfu_pkg::data_t value;
    logic           typed;
    lookup_t        result;
    lfu_pkg::cap_t  capacity;
  } row_t;

  localparam lfu_pkg::data_t KEY_MIN = 32'sh8000_0000;
  localparam lfu_pkg::data_t KEY_MAX = 32'sh7fff_ffff;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 216;
  localparam int POOL_MAX = 20;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_command;
  lfu_pkg::data_t in_key, in_value;
  logic out_valid, out_hit, out_evicted;
  logic out_ready = 1'b0;
  lfu_pkg::data_t out_read_value, out_evicted_key;
  logic psel, penable, pwrite, pready;
  logic [lfu_pkg::ADDR_BITS-1:0] paddr;
  logic [lfu_pkg::APB_BITS-1:0] pwdata, prdata;

  lfu_cache_with_lru_ties u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cache model
  logic            line_valid [lfu_pkg::ENTRIES];
  lfu_pkg::data_t  line_key   [lfu_pkg::ENTRIES];
  lfu_pkg::data_t  line_value [lfu_pkg::ENTRIES];
  lfu_pkg::count_t line_uses  [lfu_pkg::ENTRIES];
  lfu_pkg::stamp_t line_stamp [lfu_pkg::ENTRIES];
  lfu_pkg::stamp_t touch_stamp;
  int              lines_used;
  lfu_pkg::cap_t   capacity_reg;

  lookup_t pending_lookups[$];
  row_t    plan[$];
  int      mismatches = 0;
  int      send_gap_pct = 0;
  int      recv_stall_pct = 0;
  lfu_pkg::cap_t phase_caps [PHASES] = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd8, 5'd2, 5'd12};

  function automatic void cache_reset();
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) line_valid[i] = 1'b0;
    touch_stamp = '0;
    lines_used = 0;
    capacity_reg = lfu_pkg::CAP_RESET;
  endfunction

  function automatic lookup_t cache_access(logic cmd, lfu_pkg::data_t key,
                                           lfu_pkg::data_t value);
    lookup_t r;
    int slot;
    int room;
    r.hit = 1'b0;
    r.read_value = -1;
    r.evicted = 1'b0;
    r.evicted_key = '0;
    slot = -1;
    room = (capacity_reg > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(capacity_reg);
    for (int i = 0; i < lfu_pkg::ENTRIES; i++)
      if (slot < 0 && line_valid[i] && line_key[i] == key) slot = i;
    if (slot >= 0) begin
      r.hit = 1'b1;
      if (cmd == lfu_pkg::CMD_GET) r.read_value = line_value[slot];
      else line_value[slot] = value;
      if (line_uses[slot] != lfu_pkg::COUNT_MAX) line_uses[slot]++;
      touch_stamp++;
      line_stamp[slot] = touch_stamp;
    end else if (cmd == lfu_pkg::CMD_PUT && room != 0) begin
      if (lines_used >= room) begin
        // lowest use count, oldest stamp on a tie
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
          if (line_valid[i] && (slot < 0 || line_uses[i] < line_uses[slot] ||
              (line_uses[i] == line_uses[slot] && line_stamp[i] < line_stamp[slot])))
            slot = i;
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = line_key[slot];
        end
      end else begin
        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
          if (slot < 0 && !line_valid[i]) slot = i;
        if (slot >= 0) lines_used++;
      end
      if (slot >= 0) begin
        line_valid[slot] = 1'b1;
        line_key[slot] = key;
        line_value[slot] = value;
        line_uses[slot] = lfu_pkg::count_t'(1);
        touch_stamp++;
        line_stamp[slot] = touch_stamp;
      end
    end
    return r;
  endfunction

  function automatic void add_beat(logic cmd, lfu_pkg::data_t key, lfu_pkg::data_t value);
    row_t r;
    r.kind = ROW_BEAT;
    r.command = cmd;
    r.key = key;
    r.value = value;
    r.typed = 1'b0;
    r.result = '0;
    r.capacity = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_typed(logic cmd, lfu_pkg::data_t key, lfu_pkg::data_t value,
                                    logic hit, lfu_pkg::data_t rd);
    row_t r;
    r.kind = ROW_BEAT;
    r.command = cmd;
    r.key = key;
    r.value = value;
    r.typed = 1'b1;
    r.result.hit = hit;
    r.result.read_value = rd;
    r.result.evicted = 1'b0;
    r.result.evicted_key = '0;
    r.capacity = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_capacity(lfu_pkg::cap_t cap);
    row_t r;
    r.kind = ROW_CAPACITY;
    r.command = lfu_pkg::CMD_GET;
    r.key = '0;
    r.value = '0;
    r.typed = 1'b0;
    r.result = '0;
    r.capacity = cap;
    plan.push_back(r);
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, lfu_pkg::data_t want,
                                      lfu_pkg::data_t got);
    if (got !== want) flag_error($sformatf("%s expected %h got %h", name, want, got));
  endfunction

  // called and returns at a falling edge
  task automatic drive_beat(input logic cmd, input lfu_pkg::data_t key,
                            input lfu_pkg::data_t value,
                            input logic typed, input lookup_t typed_result);
    lookup_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    predicted = cache_access(cmd, key, value);
    pending_lookups.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_lookups.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_capacity(input lfu_pkg::cap_t cap);
    in_valid <= 1'b0;
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {lfu_pkg::REG_CAPACITY, 2'b00};
    pwdata <= lfu_pkg::APB_BITS'(cap);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    capacity_reg = cap;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : result_check
    lookup_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        flag_error($sformatf("unexpected beat hit=%b read_value=%h", out_hit,
                             out_read_value));
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", lfu_pkg::data_t'(want.hit), lfu_pkg::data_t'(out_hit));
        check_field("read_value", want.read_value, out_read_value);
        check_field("evicted", lfu_pkg::data_t'(want.evicted),
                    lfu_pkg::data_t'(out_evicted));
        check_field("evicted_key", want.evicted_key, out_evicted_key);
      end
    end
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    lfu_pkg::data_t key_pool [POOL_MAX];
    int pool_size;
    lfu_pkg::data_t key;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = lfu_pkg::CMD_GET;
    in_key = '0;
    in_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cache_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_typed(lfu_pkg::CMD_GET, 0, 0, 1'b0, -1);
    add_typed(lfu_pkg::CMD_PUT, KEY_MIN, KEY_MAX, 1'b0, -1);
    add_typed(lfu_pkg::CMD_GET, KEY_MIN, 0, 1'b1, KEY_MAX);
    add_typed(lfu_pkg::CMD_PUT, KEY_MAX, KEY_MIN, 1'b0, -1);
    add_typed(lfu_pkg::CMD_GET, KEY_MAX, 0, 1'b1, KEY_MIN);
    add_typed(lfu_pkg::CMD_PUT, KEY_MAX, -1, 1'b1, -1);
    add_typed(lfu_pkg::CMD_GET, KEY_MAX, 0, 1'b1, -1);
    add_typed(lfu_pkg::CMD_GET, 5, 0, 1'b0, -1);
    add_typed(lfu_pkg::CMD_PUT, -1, 0, 1'b0, -1);
    add_typed(lfu_pkg::CMD_PUT, 0, 32'sh5555_5555, 1'b0, -1);
    // lowered below occupancy: each new put evicts one
    add_capacity(2);
    add_beat(lfu_pkg::CMD_PUT, 10, 100);
    add_beat(lfu_pkg::CMD_PUT, 11, 110);
    add_beat(lfu_pkg::CMD_GET, 10, 0);
    // zero capacity: new keys are dropped, present keys still update
    add_capacity(0);
    add_typed(lfu_pkg::CMD_PUT, 12, 1, 1'b0, -1);
    add_beat(lfu_pkg::CMD_PUT, 11, 7);
    add_typed(lfu_pkg::CMD_GET, 12, 0, 1'b0, -1);
    add_beat(lfu_pkg::CMD_GET, 11, 0);
    // above entry count, clamps to full size
    add_capacity(31);
    add_beat(lfu_pkg::CMD_PUT, 32'shaaaa_aaaa, 32'sh5555_5555);
    add_capacity(1);
    add_beat(lfu_pkg::CMD_PUT, 13, 13);
    add_beat(lfu_pkg::CMD_PUT, 14, 14);
    add_beat(lfu_pkg::CMD_GET, 13, 0);
    add_beat(lfu_pkg::CMD_GET, 14, 0);
    add_capacity(16);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAPACITY) begin
        set_capacity(plan[i].capacity);
      end else begin
        drive_beat(plan[i].command, plan[i].key, plan[i].value, plan[i].typed,
                   plan[i].result);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      case (p % 4)
        0: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_gap_pct = 32;
          recv_stall_pct = 32;
        end
      endcase
      // small key pool around the capacity so hits, updates and evictions all occur
      pool_size = ((phase_caps[p] > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES
                                                      : int'(phase_caps[p])) + 3;
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (int k = 0; k < POOL_MAX; k++) key_pool[k] = lfu_pkg::data_t'($urandom);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        key = ($urandom_range(9) == 0) ? lfu_pkg::data_t'($urandom)
                                       : key_pool[$urandom_range(pool_size - 1)];
        drive_beat(1'($urandom_range(1)), key, lfu_pkg::data_t'($urandom), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (4 * (lfu_pkg::ENTRIES + 3)) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lfu_pkg.sv
hdl/lfu_ram.sv
hdl/lfu_cache_with_lru_ties.sv
hdl/lfu_chk.sv
dv/tb_top.sv
